FILE: sv/tpcc_pkg.sv
// shared types and constants of the two-player countdown clock
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package tpcc_pkg;

  localparam int TIME_W     = 24;
  localparam int QUIET_W    = 11;
  localparam int DEB_W      = 10;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;
  localparam int N_LANES    = 3;
  localparam int MAX_RES    = 3;

  localparam logic [QUIET_W-1:0] QUIET_MAX = {QUIET_W{1'b1}};

  localparam logic [CFG_DATA_W-1:0] INIT_TIME_RST = 24'd540000;
  localparam logic [DEB_W-1:0]      DEBOUNCE_RST  = 10'd50;

  localparam logic [CFG_IDX_W-1:0] CFG_INIT_TIME = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 8'd1;

  localparam logic [2:0] EV_RESET   = 3'd1;
  localparam logic [2:0] EV_START   = 3'd2;
  localparam logic [2:0] EV_SWITCH  = 3'd3;
  localparam logic [2:0] EV_TIMEOUT = 3'd4;

  localparam logic [1:0] WHO_NONE = 2'd0;
  localparam logic [1:0] WHO_P1   = 2'd1;
  localparam logic [1:0] WHO_P2   = 2'd2;

  localparam int LANE_RESET = 0;
  localparam int LANE_P1    = 1;
  localparam int LANE_P2    = 2;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_P1   = 2'd1,
    MODE_P2   = 2'd2,
    MODE_OVER = 2'd3
  } mode_e;

  typedef struct packed {
    logic reset_level;
    logic p1_level;
    logic p2_level;
  } in_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [1:0]  acting_player;
    logic [23:0] p1_remaining_ms;
    logic [23:0] p2_remaining_ms;
    logic [1:0]  clock_mode;
    logic        last_of_tick;
  } out_t;

  // all results caused by one tick
  typedef struct packed {
    logic [1:0]             n_res;
    out_t [MAX_RES-1:0]     slot;
  } bundle_t;

endpackage

`default_nettype wire

FILE: sv/two_player_countdown_clock.sv
// top level of the two-player countdown clock with debounced buttons
// depends on tpcc_pkg, tpcc_lane, tpcc_game, tpcc_outq
`timescale 1ns / 1ps
`default_nettype none

// One input transaction is one millisecond tick; three debounce lanes and the game stage
// update together, so ticks can arrive back to back. A tick causes zero to three result
// transactions. They go into a two-tick output queue and leave at one per cycle while the
// receiver does not stall, so the sustained rate is one tick per cycle as long as a tick
// yields at most one result; the results of one tick leave one after another. The input
// stalls while the queue holds two ticks not yet fully delivered. Register 0 sets the
// starting time in ms, register 1 the debounce threshold in ticks.
module two_player_countdown_clock
  import tpcc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  in_t                        in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_t                       out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic [CFG_DATA_W-1:0] init_time_q;
  logic [DEB_W-1:0]      debounce_q;
  logic                  tick;
  logic [N_LANES-1:0]    press;
  logic [N_LANES-1:0]    levels;
  logic                  full;
  bundle_t               bundle;

  assign levels     = {in_data_i.p2_level, in_data_i.p1_level, in_data_i.reset_level};
  assign in_stall_o = full;
  assign tick       = in_valid_i && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_time_q <= INIT_TIME_RST;
      debounce_q  <= DEBOUNCE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INIT_TIME: init_time_q <= cfg_data_i;
        CFG_DEBOUNCE:  debounce_q  <= cfg_data_i[DEB_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar g = 0; g < N_LANES; g++) begin : g_lane
    tpcc_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tick_i     (tick),
      .level_i    (levels[g]),
      .debounce_i (debounce_q),
      .press_o    (press[g])
    );
  end

  tpcc_game u_game (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (tick),
    .press_i     (press),
    .init_time_i (init_time_q),
    .bundle_o    (bundle)
  );

  tpcc_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (tick && (bundle.n_res != 2'd0)),
    .bundle_i    (bundle),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

FILE: sv/tpcc_lane.sv
// one debounce lane: quiet counter and stable level of one raw button
// depends on tpcc_pkg
`timescale 1ns / 1ps
`default_nettype none

module tpcc_lane
  import tpcc_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             tick_i,
  input  wire logic             level_i,
  input  wire logic [DEB_W-1:0] debounce_i,
  output logic                  press_o
);

  logic               prev_q, prev_d;
  logic               stable_q, stable_d;
  logic [QUIET_W-1:0] quiet_q, quiet_d;
  logic               change;

  always_comb begin
    if (level_i != prev_q) begin
      quiet_d = '0;
    end else if (quiet_q < QUIET_MAX) begin
      quiet_d = quiet_q + QUIET_W'(1);
    end else begin
      quiet_d = quiet_q;
    end
    change   = (quiet_d > {{(QUIET_W-DEB_W){1'b0}}, debounce_i}) && (level_i != stable_q);
    stable_d = change ? level_i : stable_q;
    prev_d   = level_i;
    press_o  = change && !level_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q   <= 1'b1;
      stable_q <= 1'b1;
      quiet_q  <= QUIET_MAX;
    end else if (tick_i) begin
      prev_q   <= prev_d;
      stable_q <= stable_d;
      quiet_q  <= quiet_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/tpcc_game.sv
// merge stage: applies the lane presses in order, runs the countdown, builds results
// depends on tpcc_pkg
`timescale 1ns / 1ps
`default_nettype none

module tpcc_game
  import tpcc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  tick_i,
  input  wire logic [N_LANES-1:0]    press_i,
  input  wire logic [CFG_DATA_W-1:0] init_time_i,
  output bundle_t                    bundle_o
);

  mode_e             mode_q, mode_d;
  logic [TIME_W-1:0] t1_q, t1_d, t2_q, t2_d;
  logic [TIME_W-1:0] t_init;
  logic [1:0]        n;
  logic              moved;

  assign t_init = TIME_W'(init_time_i);

  function automatic out_t mk(logic [2:0] kind, logic [1:0] who, logic [TIME_W-1:0] a,
                              logic [TIME_W-1:0] b, mode_e m);
    out_t r;
    r.event_kind      = kind;
    r.acting_player   = who;
    r.p1_remaining_ms = 24'(a);
    r.p2_remaining_ms = 24'(b);
    r.clock_mode      = m;
    r.last_of_tick    = 1'b0;
    return r;
  endfunction

  always_comb begin
    mode_d   = mode_q;
    t1_d     = t1_q;
    t2_d     = t2_q;
    n        = 2'd0;
    moved    = 1'b0;
    bundle_o = '0;

    if (press_i[LANE_RESET]) begin
      mode_d = MODE_IDLE;
      t1_d   = t_init;
      t2_d   = t_init;
      bundle_o.slot[n] = mk(EV_RESET, WHO_NONE, t1_d, t2_d, mode_d);
      n = n + 2'd1;
    end

    if (press_i[LANE_P1]) begin
      if (mode_d == MODE_IDLE || mode_d == MODE_P1) begin
        bundle_o.slot[n] = mk((mode_d == MODE_IDLE) ? EV_START : EV_SWITCH, WHO_P1,
                              t1_d, t2_d, MODE_P2);
        mode_d = MODE_P2;
        moved  = 1'b1;
        n = n + 2'd1;
      end
    end

    if (press_i[LANE_P2]) begin
      if (mode_d == MODE_IDLE || mode_d == MODE_P2) begin
        bundle_o.slot[n] = mk((mode_d == MODE_IDLE) ? EV_START : EV_SWITCH, WHO_P2,
                              t1_d, t2_d, MODE_P1);
        mode_d = MODE_P1;
        moved  = 1'b1;
        n = n + 2'd1;
      end
    end

    if (!moved) begin
      if (mode_d == MODE_P1) begin
        if (t1_d <= TIME_W'(1)) begin
          t1_d   = '0;
          mode_d = MODE_OVER;
          bundle_o.slot[n] = mk(EV_TIMEOUT, WHO_P1, t1_d, t2_d, mode_d);
          n = n + 2'd1;
        end else begin
          t1_d = t1_d - TIME_W'(1);
        end
      end else if (mode_d == MODE_P2) begin
        if (t2_d <= TIME_W'(1)) begin
          t2_d   = '0;
          mode_d = MODE_OVER;
          bundle_o.slot[n] = mk(EV_TIMEOUT, WHO_P2, t1_d, t2_d, mode_d);
          n = n + 2'd1;
        end else begin
          t2_d = t2_d - TIME_W'(1);
        end
      end
    end

    if (n != 2'd0) begin
      bundle_o.slot[n - 2'd1].last_of_tick = 1'b1;
    end
    bundle_o.n_res = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_IDLE;
      t1_q   <= TIME_W'(INIT_TIME_RST);
      t2_q   <= TIME_W'(INIT_TIME_RST);
    end else if (tick_i) begin
      mode_q <= mode_d;
      t1_q   <= t1_d;
      t2_q   <= t2_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/tpcc_outq.sv
// output queue: two tick bundles, drained one result transaction per cycle while the receiver does not stall
// depends on tpcc_pkg
`timescale 1ns / 1ps
`default_nettype none

module tpcc_outq
  import tpcc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  bundle_t      bundle_i,
  output logic         full_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output out_t         out_data_o
);

  bundle_t    mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;
  logic [1:0] slot_q;
  logic       take, pop;
  bundle_t    head;

  assign head        = mem_q[rd_q];
  assign full_o      = (cnt_q == 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = head.slot[slot_q];
  assign take        = out_valid_o && !out_stall_i;
  assign pop         = take && (slot_q == head.n_res - 2'd1);

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= bundle_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      cnt_q  <= 2'd0;
      slot_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop) begin
        rd_q   <= !rd_q;
        slot_q <= 2'd0;
      end else if (take) begin
        slot_q <= slot_q + 2'd1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2)
    else $error("output queue overflow");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i || pop)
    else $error("push into full queue");

  a_slot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (slot_q < head.n_res))
    else $error("slot beyond bundle result count");

  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_of_tick == (slot_q == head.n_res - 2'd1)))
    else $error("last_of_tick out of step with bundle");

  a_more_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !pop) |=> out_valid_o)
    else $error("result transaction lost inside a tick");

endmodule

`default_nettype wire

FILE: verif/tb_two_player_countdown_clock.sv
// self-checking testbench for the two-player countdown clock with debounced buttons
// depends on tpcc_pkg and two_player_countdown_clock; predicts every event transaction
// in its own model and compares each one field by field
`timescale 1ns / 1ps

module tb_two_player_countdown_clock;
  import tpcc_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int RAND_TICKS   = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = CFG_DEBOUNCE + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = {CFG_IDX_W{1'b1}};
  localparam logic [DEB_W-1:0]     DEBOUNCE_MAX  = {DEB_W{1'b1}};
  localparam logic [TIME_W-1:0]    TIME_MAX      = {TIME_W{1'b1}};

  typedef enum int {MIX_NONE, MIX_SRC, MIX_SINK, MIX_BOTH} stall_mix_e;

  logic                  clk_i       = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  in_t                   in_data     = '1;
  logic                  out_stall   = 1'b0;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx     = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  in_stall;
  logic                  out_valid;
  out_t                  out_data;

  // clock model state and its copy of the registers
  mode_e                 mdl_mode;
  logic [TIME_W-1:0]     mdl_p1_ms;
  logic [TIME_W-1:0]     mdl_p2_ms;
  logic [N_LANES-1:0]    mdl_prev;
  logic [N_LANES-1:0]    mdl_stable;
  logic [QUIET_W-1:0]    mdl_quiet [N_LANES];
  logic [TIME_W-1:0]     cfg_init_ms;
  logic [DEB_W-1:0]      cfg_debounce;

  out_t pending_events[$];
  int   n_fail       = 0;
  int   n_checked    = 0;
  int   ticks_sent   = 0;
  int   n_in_stall   = 0;
  int   cycles       = 0;
  int   src_idle_pct = 0;
  int   snk_idle_pct = 0;
  int   rx_hold_left = 0;

  two_player_countdown_clock u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver: long hold-off first, otherwise random stalls
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      out_stall <= 1'b1;
      rx_hold_left = rx_hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < snk_idle_pct);
    end
  end

  function automatic out_t make_event(input logic [2:0] kind, input logic [1:0] who);
    out_t ev;
    ev.event_kind      = kind;
    ev.acting_player   = who;
    ev.p1_remaining_ms = 24'(mdl_p1_ms);
    ev.p2_remaining_ms = 24'(mdl_p2_ms);
    ev.clock_mode      = mdl_mode;
    ev.last_of_tick    = 1'b0;
    return ev;
  endfunction

  task automatic clock_model_tick(input in_t lv);
    logic [N_LANES-1:0] lvl;
    out_t               evs[$];
    logic               moved;
    mode_e              mine;
    mode_e              other;
    logic [1:0]         who;
    int                 i;
    lvl[LANE_RESET] = lv.reset_level;
    lvl[LANE_P1]    = lv.p1_level;
    lvl[LANE_P2]    = lv.p2_level;
    moved = 1'b0;
    for (i = 0; i < N_LANES; i++) begin
      if (lvl[i] != mdl_prev[i]) begin
        mdl_quiet[i] = '0;
      end else if (mdl_quiet[i] != QUIET_MAX) begin
        mdl_quiet[i] = mdl_quiet[i] + 1'b1;
      end
      if (mdl_quiet[i] > cfg_debounce && lvl[i] != mdl_stable[i]) begin
        mdl_stable[i] = lvl[i];
        if (!lvl[i]) begin
          if (i == LANE_RESET) begin
            mdl_mode  = MODE_IDLE;
            mdl_p1_ms = cfg_init_ms;
            mdl_p2_ms = cfg_init_ms;
            evs.push_back(make_event(EV_RESET, WHO_NONE));
          end else begin
            mine  = (i == LANE_P1) ? MODE_P1 : MODE_P2;
            other = (i == LANE_P1) ? MODE_P2 : MODE_P1;
            who   = (i == LANE_P1) ? WHO_P1 : WHO_P2;
            if (mdl_mode == MODE_IDLE) begin
              mdl_mode = other;
              moved    = 1'b1;
              evs.push_back(make_event(EV_START, who));
            end else if (mdl_mode == mine) begin
              mdl_mode = other;
              moved    = 1'b1;
              evs.push_back(make_event(EV_SWITCH, who));
            end
          end
        end
      end
      mdl_prev[i] = lvl[i];
    end
    if (!moved) begin
      if (mdl_mode == MODE_P1) begin
        if (mdl_p1_ms <= 1) begin
          mdl_p1_ms = '0;
          mdl_mode  = MODE_OVER;
          evs.push_back(make_event(EV_TIMEOUT, WHO_P1));
        end else begin
          mdl_p1_ms = mdl_p1_ms - 1'b1;
        end
      end else if (mdl_mode == MODE_P2) begin
        if (mdl_p2_ms <= 1) begin
          mdl_p2_ms = '0;
          mdl_mode  = MODE_OVER;
          evs.push_back(make_event(EV_TIMEOUT, WHO_P2));
        end else begin
          mdl_p2_ms = mdl_p2_ms - 1'b1;
        end
      end
    end
    if (evs.size() > 0) evs[evs.size()-1].last_of_tick = 1'b1;
    foreach (evs[k]) pending_events.push_back(evs[k]);
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", fname, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk_i) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_events.size() == 0) begin
        $error("result transaction with none expected: %p", out_data);
        n_fail++;
      end else begin
        want = pending_events.pop_front();
        check_field("event_kind", want.event_kind, out_data.event_kind);
        check_field("acting_player", want.acting_player, out_data.acting_player);
        check_field("p1_remaining_ms", want.p1_remaining_ms, out_data.p1_remaining_ms);
        check_field("p2_remaining_ms", want.p2_remaining_ms, out_data.p2_remaining_ms);
        check_field("clock_mode", want.clock_mode, out_data.clock_mode);
        check_field("last_of_tick", want.last_of_tick, out_data.last_of_tick);
        n_checked++;
      end
    end
  end

  task automatic send_tick(input in_t lv);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= lv;
    do begin
      @(posedge clk_i);
      if (in_stall) n_in_stall++;
    end while (in_stall);
    clock_model_tick(lv);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  task automatic hold_levels(input in_t lv, input int n);
    repeat (n) send_tick(lv);
  endtask

  // hold the chosen buttons down just long enough to be accepted, then release
  task automatic press_buttons(input logic r, input logic p1, input logic p2);
    in_t lv;
    lv.reset_level = ~r;
    lv.p1_level    = ~p1;
    lv.p2_level    = ~p2;
    hold_levels(lv, cfg_debounce + 2);
    hold_levels('1, cfg_debounce + 2);
  endtask

  task automatic wait_drained();
    while (pending_events.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_INIT_TIME) begin
      cfg_init_ms = TIME_W'(val);
    end else if (idx == CFG_DEBOUNCE) begin
      cfg_debounce = val[DEB_W-1:0];
    end
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [TIME_W-1:0] init_ms, input logic [DEB_W-1:0] deb);
    in_valid <= 1'b0;
    wait_drained();
    write_reg(CFG_INIT_TIME, CFG_DATA_W'(init_ms));
    write_reg(CFG_DEBOUNCE, CFG_DATA_W'(deb));
  endtask

  task automatic set_mix(input stall_mix_e mix);
    case (mix)
      MIX_NONE: begin src_idle_pct = 0;  snk_idle_pct = 0;  end
      MIX_SRC:  begin src_idle_pct = 64; snk_idle_pct = 0;  end
      MIX_SINK: begin src_idle_pct = 0;  snk_idle_pct = 64; end
      default:  begin src_idle_pct = 30; snk_idle_pct = 30; end
    endcase
  endtask

  // registers still at their reset values: 540000 ms and 50 quiet ticks
  task automatic test_reset_values();
    in_t lv;
    lv = '1;
    lv.p1_level = 1'b0;
    hold_levels(lv, DEBOUNCE_RST + 2);
    hold_levels('1, 2);
  endtask

  task automatic test_config_masking();
    in_valid <= 1'b0;
    wait_drained();
    write_reg(CFG_UNUSED_LO, '1);
    write_reg(CFG_UNUSED_HI, '1);
    write_reg(CFG_DEBOUNCE, 24'hFFFC00);
    write_reg(CFG_INIT_TIME, 24'd20);
  endtask

  task automatic test_directed_ops();
    press_buttons(1'b1, 1'b0, 1'b0);
    press_buttons(1'b0, 1'b1, 1'b0);
    press_buttons(1'b0, 1'b1, 1'b0);
    press_buttons(1'b0, 1'b0, 1'b1);
    press_buttons(1'b0, 1'b1, 1'b1);
    press_buttons(1'b1, 1'b1, 1'b1);
    hold_levels('1, 25);
    press_buttons(1'b0, 1'b0, 1'b1);
    press_buttons(1'b1, 1'b0, 1'b0);
  endtask

  task automatic test_time_extremes();
    configure('0, '0);
    press_buttons(1'b1, 1'b0, 1'b0);
    press_buttons(1'b0, 1'b1, 1'b0);
    configure(TIME_W'(1), '0);
    press_buttons(1'b1, 1'b0, 1'b0);
    press_buttons(1'b0, 1'b0, 1'b1);
    configure(TIME_MAX, '0);
    press_buttons(1'b1, 1'b0, 1'b0);
    press_buttons(1'b0, 1'b1, 1'b0);
    press_buttons(1'b1, 1'b0, 1'b0);
  endtask

  task automatic test_random_play(input stall_mix_e mix);
    int              start;
    int              k;
    logic [2:0]      r3;
    logic [TIME_W-1:0] init_ms;
    init_ms = ($urandom_range(3) == 0) ? TIME_W'($urandom) : TIME_W'($urandom_range(60, 2));
    configure(init_ms, DEB_W'($urandom_range(3)));
    set_mix(mix);
    start = ticks_sent;
    while (ticks_sent - start < RAND_TICKS) begin
      k = $urandom_range(99);
      if (k < 65) begin
        press_buttons($urandom_range(9) == 0, 1'($urandom_range(1)),
                      1'($urandom_range(1)));
      end else if (k < 85) begin
        // level held too briefly to be accepted
        r3 = 3'($urandom_range(7));
        hold_levels(r3, $urandom_range(cfg_debounce + 1, 1));
      end else begin
        r3 = 3'($urandom_range(7));
        hold_levels(r3, 1);
      end
      hold_levels('1, $urandom_range(6));
    end
    hold_levels('1, cfg_debounce + 2);
  endtask

  // receiver holds off while the sender keeps producing events
  task automatic test_backpressure();
    int k;
    configure(TIME_W'(1000), '0);
    set_mix(MIX_NONE);
    rx_hold_left = HOLD_CYCLES;
    press_buttons(1'b1, 1'b0, 1'b0);
    for (k = 0; k < 8; k++) begin
      press_buttons(1'b0, k % 2 == 0, k % 2 == 1);
    end
  endtask

  // largest debounce: a short reset press is ignored while the clock keeps running
  task automatic test_long_debounce();
    in_t lv;
    configure(TIME_W'(7), DEBOUNCE_MAX);
    lv = '1;
    lv.reset_level = 1'b0;
    hold_levels(lv, 20);
    hold_levels('1, 2);
  endtask

  initial begin
    mdl_mode     = MODE_IDLE;
    cfg_init_ms  = INIT_TIME_RST;
    cfg_debounce = DEBOUNCE_RST;
    mdl_p1_ms    = INIT_TIME_RST;
    mdl_p2_ms    = INIT_TIME_RST;
    mdl_prev     = '1;
    mdl_stable   = '1;
    foreach (mdl_quiet[i]) mdl_quiet[i] = QUIET_MAX;
    repeat (9) @(negedge clk_i);
    rst_n <= 1'b1;
    @(negedge clk_i);

    test_reset_values();
    test_config_masking();
    test_directed_ops();
    test_time_extremes();
    test_random_play(MIX_NONE);
    test_random_play(MIX_SRC);
    test_random_play(MIX_SINK);
    test_random_play(MIX_BOTH);
    test_backpressure();
    test_long_debounce();

    in_valid <= 1'b0;
    wait_drained();
    $display("tb: %0d ticks sent, %0d event transactions checked, input stalled %0d cycles",
             ticks_sent, n_checked, n_in_stall);
    $display("tb: reset values, register masking, all events, time extremes, four idle mixes,");
    $display("tb: receiver hold-off and a short press under the largest debounce were run");
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/tpcc_pkg.sv
sv/tpcc_lane.sv
sv/tpcc_game.sv
sv/tpcc_outq.sv
sv/two_player_countdown_clock.sv
verif/tb_two_player_countdown_clock.sv
